// ===== hdl/pva_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pva_pkg
// Shared types and constants of the polyphonic voice allocator.
// ----------------------------------------------------------------------------
package pva_pkg;

  localparam int NOTE_W      = 7;
  localparam int NOTE_CNT    = 128;
  localparam int STAMP_W     = 8;
  localparam int COUNT_W     = 8;
  localparam int VOICE_OUT_W = 3;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;

  // event kinds
  localparam logic KIND_ON  = 1'b0;
  localparam logic KIND_OFF = 1'b1;

  // result commands
  localparam logic CMD_TRIGGER = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // register index bit (paddr[2]) of mono_mode
  localparam logic REG_MONO_MODE = 1'b0;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAP,
    ST_DISPATCH,
    ST_FREE,
    ST_OLDEST,
    ST_ASSIGN,
    ST_MATCH,
    ST_FREEV,
    ST_HAND
  } pva_state_e;

  typedef enum logic [2:0] {
    EMIT_TRIG,
    EMIT_REL,
    EMIT_HAND,
    EMIT_MONO_TRIG,
    EMIT_MONO_REL
  } pva_emit_e;

  typedef struct packed {
    logic      load;          // latch event, read its held bit
    logic      map_update;    // write held bit, adjust count
    logic      clr_step;      // clear one held-note entry
    logic      free_start;    // advance cursor, reset probe count
    logic      free_step;     // advance cursor, count probe
    logic      idx_clear;     // restart voice index and oldest search
    logic      idx_step;
    logic      oldest_cmp;
    logic      assign_voice;  // cursor voice takes the event note
    logic      free_voice;    // indexed voice becomes free
    logic      clear_voices;
    logic      scan_start;
    logic      scan_step;
    logic      hand_assign;   // indexed voice takes the scanned note
    logic      emit;
    pva_emit_e emit_sel;
  } pva_ctrl_t;

  typedef struct packed {
    logic kind_off;
    logic count_zero;
    logic count_le_n;
    logic count_ge_n;
    logic free_stop;
    logic idx_last;
    logic match_hit;
    logic hand_hit;
    logic scan_last;
  } pva_stat_t;

endpackage
`default_nettype wire

// ===== hdl/pva_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pva_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pva_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 128
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(DEPTH)-1:0] waddr_i,
  input  wire [WIDTH-1:0]         wdata_i,
  input  wire [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== hdl/pva_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pva_ctrl
// Sequencer of the voice allocator: clearing pass, event dispatch and scans.
// ----------------------------------------------------------------------------
module pva_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start_i,
  input  wire                 mono_i,
  input  pva_pkg::pva_stat_t  stat_i,
  output logic                busy_o,
  output pva_pkg::pva_ctrl_t  ctrl_o
);

  import pva_pkg::*;

  pva_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (stat_i.scan_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) state_d = ST_MAP;
      end
      ST_MAP: state_d = ST_DISPATCH;
      ST_DISPATCH: begin
        priority if (mono_i) state_d = ST_IDLE;
        else if (stat_i.kind_off) state_d = ST_MATCH;
        else if (stat_i.count_le_n) state_d = ST_FREE;
        else state_d = ST_OLDEST;
      end
      ST_FREE: begin
        if (stat_i.free_stop) state_d = ST_ASSIGN;
      end
      ST_OLDEST: begin
        if (stat_i.idx_last) state_d = ST_ASSIGN;
      end
      ST_ASSIGN: state_d = ST_IDLE;
      ST_MATCH: begin
        priority if (stat_i.match_hit) state_d = ST_FREEV;
        else if (stat_i.idx_last) state_d = ST_IDLE;
      end
      ST_FREEV: begin
        state_d = stat_i.count_ge_n ? ST_HAND : ST_IDLE;
      end
      ST_HAND: begin
        if (stat_i.hand_hit || stat_i.scan_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    ctrl_o = '0;
    unique case (state_q)
      ST_CLEAR: ctrl_o.clr_step = 1'b1;
      ST_IDLE:  ctrl_o.load = start_i;
      ST_MAP:   ctrl_o.map_update = 1'b1;
      ST_DISPATCH: begin
        priority if (mono_i) begin
          if (!stat_i.kind_off) begin
            ctrl_o.emit     = 1'b1;
            ctrl_o.emit_sel = EMIT_MONO_TRIG;
          end else if (stat_i.count_zero) begin
            ctrl_o.clear_voices = 1'b1;
            ctrl_o.emit         = 1'b1;
            ctrl_o.emit_sel     = EMIT_MONO_REL;
          end
        end else if (!stat_i.kind_off && stat_i.count_le_n) begin
          ctrl_o.free_start = 1'b1;
        end else begin
          ctrl_o.idx_clear = 1'b1;
        end
      end
      ST_FREE: ctrl_o.free_step = !stat_i.free_stop;
      ST_OLDEST: begin
        ctrl_o.oldest_cmp = 1'b1;
        ctrl_o.idx_step   = 1'b1;
      end
      ST_ASSIGN: begin
        ctrl_o.assign_voice = 1'b1;
        ctrl_o.emit         = 1'b1;
        ctrl_o.emit_sel     = EMIT_TRIG;
      end
      ST_MATCH: ctrl_o.idx_step = !stat_i.match_hit;
      ST_FREEV: begin
        ctrl_o.free_voice = 1'b1;
        if (stat_i.count_ge_n) begin
          ctrl_o.scan_start = 1'b1;
        end else begin
          ctrl_o.emit     = 1'b1;
          ctrl_o.emit_sel = EMIT_REL;
        end
      end
      ST_HAND: begin
        priority if (stat_i.hand_hit) begin
          ctrl_o.hand_assign = 1'b1;
          ctrl_o.emit        = 1'b1;
          ctrl_o.emit_sel    = EMIT_HAND;
        end else if (stat_i.scan_last) begin
          ctrl_o.emit     = 1'b1;
          ctrl_o.emit_sel = EMIT_REL;
        end else begin
          ctrl_o.scan_step = 1'b1;
        end
      end
      default: ctrl_o = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/pva_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pva_datapath
// Held-note map, held count, voice table, cursor, scan counters and result
// register of the voice allocator.
// ----------------------------------------------------------------------------
module pva_datapath #(
  parameter int NUM_VOICES = 6
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  pva_pkg::pva_ctrl_t                 ctrl_i,
  output pva_pkg::pva_stat_t                 stat_o,
  input  wire                                kind_i,
  input  wire [pva_pkg::NOTE_W-1:0]          note_i,
  output logic                               result_strobe_o,
  output logic                               command_o,
  output logic [pva_pkg::VOICE_OUT_W-1:0]    voice_out_o,
  output logic [pva_pkg::NOTE_W-1:0]         note_out_o,
  output logic                               jump_sustain_o
);

  import pva_pkg::*;

  localparam int VIDX_W = $clog2(NUM_VOICES);
  localparam int K_W    = $clog2(NUM_VOICES + 1);

  logic               kind_q;
  logic [NOTE_W-1:0]  note_q;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [VIDX_W-1:0]  cursor_q, cursor_d, cursor_nxt;
  logic [K_W-1:0]     k_q;
  logic [VIDX_W-1:0]  idx_q;
  logic [STAMP_W:0]   best_q;
  logic [NOTE_W-1:0]  scan_n_q, scan_n_d;

  logic [NOTE_W-1:0]  vnote_q  [NUM_VOICES];
  logic [STAMP_W-1:0] vstamp_q [NUM_VOICES];

  logic               held;
  logic [0:0]         ram_rdata;
  logic               ram_we;
  logic [NOTE_W-1:0]  ram_waddr, ram_raddr;
  logic [0:0]         ram_wdata;
  logic               take_oldest;
  logic               assigned;

  // held-note map
  pva_ram #(
    .WIDTH(1),
    .DEPTH(NOTE_CNT)
  ) u_held_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign held      = ram_rdata[0];
  assign ram_we    = ctrl_i.clr_step | ctrl_i.map_update;
  assign ram_waddr = ctrl_i.clr_step ? scan_n_q : note_q;
  assign ram_wdata = ctrl_i.clr_step ? 1'b0 : (kind_q == KIND_ON);
  assign ram_raddr = ctrl_i.load ? note_i : scan_n_d;

  always_comb begin
    scan_n_d = scan_n_q;
    priority if (ctrl_i.scan_start) scan_n_d = '0;
    else if (ctrl_i.scan_step || ctrl_i.clr_step) scan_n_d = scan_n_q + NOTE_W'(1);
  end

  always_comb begin
    count_d = count_q;
    if (ctrl_i.map_update) begin
      if (kind_q == KIND_ON && !held) begin
        count_d = count_q + COUNT_W'(1);
      end else if (kind_q == KIND_OFF && held) begin
        count_d = count_q - COUNT_W'(1);
      end
    end
  end

  assign cursor_nxt  = (cursor_q == VIDX_W'(NUM_VOICES - 1)) ? '0 : cursor_q + VIDX_W'(1);
  assign take_oldest = (vstamp_q[idx_q] != '0) && ({1'b0, vstamp_q[idx_q]} < best_q);

  always_comb begin
    cursor_d = cursor_q;
    priority if (ctrl_i.free_start || ctrl_i.free_step) cursor_d = cursor_nxt;
    else if (ctrl_i.oldest_cmp && take_oldest) cursor_d = idx_q;
  end

  // is the scanned note already played by some busy voice
  always_comb begin
    assigned = 1'b0;
    for (int v = 0; v < NUM_VOICES; v++) begin
      if (vstamp_q[v] != '0 && vnote_q[v] == scan_n_q) assigned = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      kind_q <= kind_i;
      note_q <= note_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      cursor_q <= '0;
      k_q      <= '0;
      idx_q    <= '0;
      best_q   <= '0;
      scan_n_q <= '0;
    end else begin
      count_q  <= count_d;
      cursor_q <= cursor_d;
      scan_n_q <= scan_n_d;
      if (ctrl_i.free_start) begin
        k_q <= '0;
      end else if (ctrl_i.free_step) begin
        k_q <= k_q + K_W'(1);
      end
      if (ctrl_i.idx_clear) begin
        idx_q  <= '0;
        best_q <= {1'b1, {STAMP_W{1'b0}}};
      end else begin
        if (ctrl_i.idx_step) idx_q <= idx_q + VIDX_W'(1);
        if (ctrl_i.oldest_cmp && take_oldest) best_q <= {1'b0, vstamp_q[idx_q]};
      end
    end
  end

  // voice table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int v = 0; v < NUM_VOICES; v++) begin
        vnote_q[v]  <= '0;
        vstamp_q[v] <= '0;
      end
    end else begin
      for (int v = 0; v < NUM_VOICES; v++) begin
        priority if (ctrl_i.clear_voices) begin
          vnote_q[v]  <= '0;
          vstamp_q[v] <= '0;
        end else if (ctrl_i.assign_voice && cursor_q == VIDX_W'(v)) begin
          vnote_q[v]  <= note_q;
          vstamp_q[v] <= STAMP_W'(count_q);
        end else if (ctrl_i.free_voice && idx_q == VIDX_W'(v)) begin
          vnote_q[v]  <= '0;
          vstamp_q[v] <= '0;
        end else if (ctrl_i.hand_assign && idx_q == VIDX_W'(v)) begin
          vnote_q[v]  <= scan_n_q;
          vstamp_q[v] <= STAMP_W'(1);
        end
      end
    end
  end

  // status
  assign stat_o.kind_off   = (kind_q == KIND_OFF);
  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.count_le_n = (count_q <= COUNT_W'(NUM_VOICES));
  assign stat_o.count_ge_n = (count_q >= COUNT_W'(NUM_VOICES));
  assign stat_o.free_stop  = (k_q == K_W'(NUM_VOICES)) || (vstamp_q[cursor_q] == '0);
  assign stat_o.idx_last   = (idx_q == VIDX_W'(NUM_VOICES - 1));
  assign stat_o.match_hit  = (vstamp_q[idx_q] != '0) && (vnote_q[idx_q] == note_q);
  assign stat_o.hand_hit   = held && !assigned;
  assign stat_o.scan_last  = (scan_n_q == NOTE_W'(NOTE_CNT - 1));

  // result register, a one-cycle strobe per transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_strobe_o <= 1'b0;
    end else begin
      result_strobe_o <= ctrl_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit) begin
      unique case (ctrl_i.emit_sel)
        EMIT_TRIG: begin
          command_o      <= CMD_TRIGGER;
          voice_out_o    <= VOICE_OUT_W'({1'b0, cursor_q} + (VIDX_W + 1)'(1));
          note_out_o     <= note_q;
          jump_sustain_o <= 1'b0;
        end
        EMIT_REL: begin
          command_o      <= CMD_RELEASE;
          voice_out_o    <= VOICE_OUT_W'({1'b0, idx_q} + (VIDX_W + 1)'(1));
          note_out_o     <= '0;
          jump_sustain_o <= 1'b0;
        end
        EMIT_HAND: begin
          command_o      <= CMD_TRIGGER;
          voice_out_o    <= VOICE_OUT_W'({1'b0, idx_q} + (VIDX_W + 1)'(1));
          note_out_o     <= scan_n_q;
          jump_sustain_o <= 1'b1;
        end
        EMIT_MONO_TRIG: begin
          command_o      <= CMD_TRIGGER;
          voice_out_o    <= '0;
          note_out_o     <= note_q;
          jump_sustain_o <= 1'b0;
        end
        EMIT_MONO_REL: begin
          command_o      <= CMD_RELEASE;
          voice_out_o    <= '0;
          note_out_o     <= '0;
          jump_sustain_o <= 1'b0;
        end
        default: begin
          command_o      <= CMD_RELEASE;
          voice_out_o    <= '0;
          note_out_o     <= '0;
          jump_sustain_o <= 1'b0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/poly_voice_allocator_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// poly_voice_allocator_top
// Polyphonic voice allocator: round robin with oldest-voice stealing.
// ----------------------------------------------------------------------------
// Usage:
//   An event (kind_i, note_i) is taken at a rising edge with start high and
//   busy low. Each event yields zero or one result, shown on command_o,
//   voice_out_o, note_out_o and jump_sustain_o for exactly one cycle while
//   result_strobe_o is high. The receiver cannot stall; the result
//   transaction appears in the first cycle busy is low again, so the next
//   event may be started in that same cycle.
//   Work from accept to busy low: a mono event ends at its dispatch, a
//   note-on runs the free-voice probe or oldest-voice search, one voice per
//   cycle, and a note-off may run the hand-over scan that reads the
//   held-note RAM one note per cycle.
//   mono_mode sits at byte address 0 of the APB port; write it only while
//   busy is low.
//   After reset the block clears every entry of the held-note RAM with
//   busy high; APB writes are taken during that time.
// ----------------------------------------------------------------------------
module poly_voice_allocator_top #(
  parameter int NUM_VOICES = 6
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  start,
  output logic                                 busy,
  input  wire                                  psel,
  input  wire                                  penable,
  input  wire                                  pwrite,
  input  wire [pva_pkg::APB_ADDR_W-1:0]        paddr,
  input  wire [pva_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [pva_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                 pready,
  input  wire                                  kind_i,
  input  wire [pva_pkg::NOTE_W-1:0]            note_i,
  output logic                                 result_strobe_o,
  output logic                                 command_o,
  output logic [pva_pkg::VOICE_OUT_W-1:0]      voice_out_o,
  output logic [pva_pkg::NOTE_W-1:0]           note_out_o,
  output logic                                 jump_sustain_o
);

  import pva_pkg::*;

  logic      mono_q;
  logic      cfg_wr;
  pva_ctrl_t ctrl;
  pva_stat_t stat;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_MONO_MODE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mono_q <= 1'b0;
    end else if (cfg_wr) begin
      mono_q <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_MONO_MODE) ? {{(APB_DATA_W - 1){1'b0}}, mono_q} : '0;

  pva_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .mono_i (mono_q),
    .stat_i (stat),
    .busy_o (busy),
    .ctrl_o (ctrl)
  );

  pva_datapath #(
    .NUM_VOICES(NUM_VOICES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .kind_i         (kind_i),
    .note_i         (note_i),
    .result_strobe_o(result_strobe_o),
    .command_o      (command_o),
    .voice_out_o    (voice_out_o),
    .note_out_o     (note_out_o),
    .jump_sustain_o (jump_sustain_o)
  );

  a_busy_after_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after an accepted event");

  a_strobe_ends_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> $past(busy) && !busy)
    else $error("result strobe outside the end of an event");

  a_release_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && command_o == CMD_RELEASE |-> note_out_o == '0 && !jump_sustain_o)
    else $error("release result carries a note or jump-sustain");

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of poly_voice_allocator_top. Note events go in
// through the start/busy handshake. A voice-allocation model inside the
// bench predicts each voice command, and every strobed command is compared
// with it field by field. Directed tests cover round-robin wrap, mono
// broadcast and release, stealing and hand-over. Random traffic then runs
// in phases with mono_mode switched over APB.
// ----------------------------------------------------------------------------
module tb;
  import pva_pkg::*;

  localparam int NUM_VOICES    = 6;
  localparam int SETTLE_CYCLES = NUM_VOICES + 140;
  localparam int WDOG_LIMIT    = 4000;
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_EVENTS  = 100;
  localparam int IDLE_PCT      = 27;
  localparam int CALM_PHASE    = 3;
  // phases that run in mono mode
  localparam logic [RAND_PHASES-1:0] PHASE_MONO = 8'b0001_0010;
  localparam logic [APB_ADDR_W-1:0] ADDR_MONO_MODE = {REG_MONO_MODE, 2'b00};

  typedef struct packed {
    logic                   cmd;
    logic [VOICE_OUT_W-1:0] voice;
    logic [NOTE_W-1:0]      note;
    logic                   js;
  } voice_cmd_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start;
  logic                   busy;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [APB_ADDR_W-1:0]  paddr;
  logic [APB_DATA_W-1:0]  pwdata;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;
  logic                   kind_i;
  logic [NOTE_W-1:0]      note_i;
  logic                   result_strobe_o;
  logic                   command_o;
  logic [VOICE_OUT_W-1:0] voice_out_o;
  logic [NOTE_W-1:0]      note_out_o;
  logic                   jump_sustain_o;

  // allocation model state
  logic                   mono_q;
  logic [NOTE_CNT-1:0]    held_map;
  logic [COUNT_W-1:0]     held_cnt;
  logic [NOTE_W-1:0]      vnote  [NUM_VOICES];
  logic [STAMP_W-1:0]     vstamp [NUM_VOICES];
  logic [2:0]             rr_cursor;

  voice_cmd_t pending_cmds[$];
  int events_sent;
  int cmds_seen;
  int mismatches;
  int cfg_writes;
  int idle_cycles;
  bit idle_en;

  poly_voice_allocator_top #(.NUM_VOICES(NUM_VOICES)) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .kind_i          (kind_i),
    .note_i          (note_i),
    .result_strobe_o (result_strobe_o),
    .command_o       (command_o),
    .voice_out_o     (voice_out_o),
    .note_out_o      (note_out_o),
    .jump_sustain_o  (jump_sustain_o)
  );

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [2:0] next_slot(input logic [2:0] v);
    return (v == NUM_VOICES - 1) ? 3'd0 : v + 3'd1;
  endfunction

  function automatic bit note_on_voice(input logic [NOTE_W-1:0] n);
    int k;
    for (k = 0; k < NUM_VOICES; k++)
      if (vstamp[k] != 0 && vnote[k] == n) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [NOTE_W-1:0] next_held(input logic [NOTE_W-1:0] n);
    logic [NOTE_W-1:0] m;
    m = n;
    while (!held_map[m]) m = m + 1'b1;
    return m;
  endfunction

  // Update the allocation state for one event; return 1 with the voice command
  // it produces, or 0 when it produces none.
  function automatic bit allocate_voice(input logic k, input logic [NOTE_W-1:0] n,
                                        output voice_cmd_t c);
    int i;
    int h;
    int best;
    c = '0;
    if (k == KIND_ON) begin
      if (!held_map[n]) begin
        held_map[n] = 1'b1;
        held_cnt = held_cnt + 1'b1;
      end
      c.cmd  = CMD_TRIGGER;
      c.note = n;
      if (mono_q) return 1'b1;
      if (held_cnt <= NUM_VOICES) begin
        // probe for a free voice; after a full turn, overwrite
        rr_cursor = next_slot(rr_cursor);
        for (i = 0; i < NUM_VOICES; i++) begin
          if (vstamp[rr_cursor] == 0) break;
          rr_cursor = next_slot(rr_cursor);
        end
      end else begin
        best = 256;
        for (i = 0; i < NUM_VOICES; i++) begin
          if (vstamp[i] != 0 && vstamp[i] < best) begin
            best = vstamp[i];
            rr_cursor = i[2:0];
          end
        end
      end
      vnote[rr_cursor]  = n;
      vstamp[rr_cursor] = held_cnt;
      c.voice = rr_cursor + 3'd1;
      return 1'b1;
    end

    if (held_map[n]) begin
      held_map[n] = 1'b0;
      held_cnt = held_cnt - 1'b1;
    end
    if (mono_q) begin
      if (held_cnt != 0) return 1'b0;
      for (i = 0; i < NUM_VOICES; i++) begin
        vnote[i]  = '0;
        vstamp[i] = '0;
      end
      c.cmd = CMD_RELEASE;
      return 1'b1;
    end
    for (i = 0; i < NUM_VOICES; i++)
      if (vstamp[i] != 0 && vnote[i] == n) break;
    if (i >= NUM_VOICES) return 1'b0;
    vnote[i]  = '0;
    vstamp[i] = '0;
    c.voice = i[2:0] + 3'd1;
    if (held_cnt >= NUM_VOICES) begin
      // hand the voice to the lowest held note without a voice
      for (h = 0; h < NOTE_CNT; h++) begin
        if (held_map[h] && !note_on_voice(h[NOTE_W-1:0])) begin
          vnote[i]  = h[NOTE_W-1:0];
          vstamp[i] = STAMP_W'(1);
          c.cmd  = CMD_TRIGGER;
          c.note = h[NOTE_W-1:0];
          c.js   = 1'b1;
          return 1'b1;
        end
      end
    end
    c.cmd = CMD_RELEASE;
    return 1'b1;
  endfunction

  // Compare each strobed command with the oldest prediction.
  always @(posedge clk_i) begin
    voice_cmd_t want;
    if (rst_ni && result_strobe_o) begin
      cmds_seen++;
      if (pending_cmds.size() == 0) begin
        $error("unexpected command: cmd %0d voice %0d note %0d js %0d",
               command_o, voice_out_o, note_out_o, jump_sustain_o);
        mismatches++;
      end else begin
        want = pending_cmds.pop_front();
        if (command_o !== want.cmd) begin
          $error("command: expected %0d, got %0d", want.cmd, command_o);
          mismatches++;
        end
        if (voice_out_o !== want.voice) begin
          $error("voice_out: expected %0d, got %0d", want.voice, voice_out_o);
          mismatches++;
        end
        if (note_out_o !== want.note) begin
          $error("note_out: expected %0d, got %0d", want.note, note_out_o);
          mismatches++;
        end
        if (jump_sustain_o !== want.js) begin
          $error("jump_sustain: expected %0d, got %0d", want.js, jump_sustain_o);
          mismatches++;
        end
      end
    end
  end

  // Abort when no transaction of any kind completes for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_strobe_o || (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WDOG_LIMIT);
        $display("[poly_voice_allocator_top] ERROR");
        $finish;
      end
    end
  end

  task automatic send_event(input logic k, input logic [NOTE_W-1:0] n);
    voice_cmd_t c;
    @(negedge clk_i);
    if (idle_en) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        start <= 1'b0;
        @(negedge clk_i);
      end
    end
    start  <= 1'b1;
    kind_i <= k;
    note_i <= n;
    do @(posedge clk_i); while (busy !== 1'b0);
    events_sent++;
    if (allocate_voice(k, n, c)) pending_cmds.push_back(c);
  endtask

  // Drop start, drain all predicted commands, then let a silent event finish.
  task automatic settle();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_mono(input logic val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_MONO_MODE;
    pwdata  <= {{(APB_DATA_W-1){1'b0}}, val};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    mono_q = val;
    cfg_writes++;
    // read back
    @(negedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {{(APB_DATA_W-1){1'b0}}, val}) begin
      $error("mono_mode readback: expected %0d, got %0h", val, prdata);
      mismatches++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Notes 0 and 127, repeats that fill every voice and wrap the probe,
  // a release that hits no voice.
  task automatic test_round_robin();
    send_event(KIND_ON, 7'd0);
    repeat (6) send_event(KIND_ON, 7'd127);
    send_event(KIND_OFF, 7'd5);
    send_event(KIND_OFF, 7'd127);
    send_event(KIND_OFF, 7'd0);
    settle();
  endtask

  // Mono broadcast and release-all, then steal with every voice free,
  // steal the oldest and hand the freed voice to a held note.
  task automatic test_mono_and_steal();
    int n;
    write_mono(1'b1);
    send_event(KIND_ON, 7'd40);
    send_event(KIND_OFF, 7'd40);
    send_event(KIND_OFF, 7'd40);
    for (n = 40; n <= 46; n++) send_event(KIND_ON, n[NOTE_W-1:0]);
    send_event(KIND_ON, 7'd46);
    send_event(KIND_OFF, 7'd40);
    settle();
    write_mono(1'b0);
    send_event(KIND_ON, 7'd47);
    send_event(KIND_ON, 7'd48);
    send_event(KIND_OFF, 7'd48);
    settle();
  endtask

  // Mostly plausible playing: new notes on, held notes off, with the held
  // count kept around the voice count; the rest is noise.
  task automatic pick_event(output logic k, output logic [NOTE_W-1:0] n);
    int lo_mark;
    int hi_mark;
    int p_on;
    lo_mark = mono_q ? 1 : 3;
    hi_mark = mono_q ? 4 : 11;
    p_on = (held_cnt < lo_mark) ? 80 : (held_cnt > hi_mark) ? 20 : 50;
    n = NOTE_W'($urandom_range(NOTE_CNT - 1));
    if ($urandom_range(99) < 12) begin
      k = 1'($urandom_range(1));
      if ($urandom_range(1) && held_cnt != 0) n = next_held(n);
    end else if ($urandom_range(99) < p_on || held_cnt == 0) begin
      k = KIND_ON;
      if (held_cnt < NOTE_CNT)
        while (held_map[n]) n = n + 1'b1;
    end else begin
      k = KIND_OFF;
      n = next_held(n);
    end
  endtask

  task automatic test_random_traffic();
    int p;
    int e;
    logic k;
    logic [NOTE_W-1:0] n;
    for (p = 0; p < RAND_PHASES; p++) begin
      settle();
      write_mono(PHASE_MONO[p]);
      idle_en = (p != CALM_PHASE);
      for (e = 0; e < PHASE_EVENTS; e++) begin
        pick_event(k, n);
        send_event(k, n);
      end
    end
    idle_en = 1'b1;
  endtask

  initial begin
    int i;
    rst_ni  = 1'b0;
    start   = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    kind_i  = 1'b0;
    note_i  = '0;
    idle_en = 1'b1;
    mono_q    = 1'b0;
    held_map  = '0;
    held_cnt  = '0;
    rr_cursor = '0;
    for (i = 0; i < NUM_VOICES; i++) begin
      vnote[i]  = '0;
      vstamp[i] = '0;
    end
    events_sent = 0;
    cmds_seen   = 0;
    mismatches  = 0;
    cfg_writes  = 0;
    idle_cycles = 0;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_round_robin();
    test_mono_and_steal();
    test_random_traffic();
    settle();

    $display("%0d note events, %0d voice commands checked, %0d mono_mode writes",
             events_sent, cmds_seen, cfg_writes);
    $display("covered: round-robin wrap, oldest steal, hand-over, mono broadcast/release");
    if (mismatches == 0) begin
      $display("[poly_voice_allocator_top] OK");
    end else begin
      $display("[poly_voice_allocator_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== poly_voice_allocator_top.f =====
hdl/pva_pkg.sv
hdl/pva_ram.sv
hdl/pva_ctrl.sv
hdl/pva_datapath.sv
hdl/poly_voice_allocator_top.sv
tb/tb.sv
